// ----- sv/mlf_pkg.sv -----
package mlf_pkg;

   localparam int MAC_W  = 48;
   localparam int PORT_W = 3;
   localparam int MASK_W = 8;
   localparam int CSR_W  = 4;

   localparam logic [CSR_W-1:0] ACTIVE_PORTS_RESET = 4'd8;

   localparam int TABLE_ENTRIES_DEFAULT = 64;
   localparam int MAX_PORTS_DEFAULT     = 8;

   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

   typedef struct packed {
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic [PORT_W-1:0] in_port;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] egress_mask;
      logic              flooded;
      logic              learned;
      logic              learn_dropped;
   } rsp_type;

   typedef struct packed {
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic [PORT_W-1:0] in_port;
      logic [MASK_W-1:0] flood_mask;
   } work_type;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
   } entry_type;

endpackage

// ----- sv/mlf_front.sv -----
module mlf_front #(
   parameter int MAX_PORTS = mlf_pkg::MAX_PORTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [mlf_pkg::CSR_W-1:0]   csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  mlf_pkg::req_type            req_payload,
   output logic                        push_valid,
   input  logic                        push_ready,
   output mlf_pkg::work_type           push_data
);

   localparam int MW = mlf_pkg::MASK_W;
   localparam int CW = mlf_pkg::CSR_W;
   localparam int PW = mlf_pkg::PORT_W;

   logic [CW-1:0] active_ports_ff;
   logic [MW-1:0] flood_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ports_ff <= mlf_pkg::ACTIVE_PORTS_RESET;
      end else if (csr_wr_en) begin
         active_ports_ff <= csr_wr_data;
      end
   end

   // flood to every active port but the ingress one
   always_comb begin
      for (int i = 0; i < MW; i++) begin
         flood_mask[i] = (active_ports_ff > CW'(i)) && (i < MAX_PORTS) &&
                         (req_payload.in_port != PW'(i));
      end
   end

   assign push_valid           = req_valid;
   assign req_ready            = push_ready;
   assign push_data.src_mac    = req_payload.src_mac;
   assign push_data.dst_mac    = req_payload.dst_mac;
   assign push_data.in_port    = req_payload.in_port;
   assign push_data.flood_mask = flood_mask;

endmodule

// ----- sv/mlf_queue.sv -----
module mlf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  mlf_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output mlf_pkg::work_type pop_data
);

   localparam int AW    = mlf_pkg::QUEUE_AW;
   localparam int DEPTH = mlf_pkg::QUEUE_DEPTH;

   mlf_pkg::work_type slot_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff;
   logic [AW-1:0]     rd_ptr_ff;
   logic [AW:0]       fill_ff;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (fill_ff != (AW+1)'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + (AW+1)'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - (AW+1)'(1);
         end
      end
   end

endmodule

// ----- sv/mlf_back.sv -----
module mlf_back #(
   parameter int TABLE_ENTRIES = mlf_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  mlf_pkg::work_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mlf_pkg::rsp_type  rsp_payload
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int MW = mlf_pkg::MASK_W;
   localparam int PW = mlf_pkg::PORT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_FINISH
   } state_type;

   state_type          state_ff;
   mlf_pkg::work_type  work_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;
   logic               cmp_valid_ff;
   logic               dst_hit_ff;
   logic [PW-1:0]      dst_port_ff;
   logic               src_hit_ff;
   logic               rsp_valid_ff;
   mlf_pkg::rsp_type   rsp_ff;

   mlf_pkg::entry_type mem [TABLE_ENTRIES];
   mlf_pkg::entry_type rd_data_ff;

   logic               issue;
   logic [IW-1:0]      rd_addr;
   logic               dst_match;
   logic               src_match;
   logic               out_free;
   logic               learn_ok;
   logic               mem_we;
   mlf_pkg::rsp_type   result;

   always_comb begin
      issue     = (state_ff == S_SEARCH) && (idx_ff < count_ff);
      rd_addr   = idx_ff[IW-1:0];
      dst_match = cmp_valid_ff && (rd_data_ff.mac == work_ff.dst_mac);
      src_match = cmp_valid_ff && (rd_data_ff.mac == work_ff.src_mac);
      out_free  = !rsp_valid_ff || rsp_ready;
      learn_ok  = count_ff < CW'(TABLE_ENTRIES);
      mem_we    = (state_ff == S_FINISH) && out_free && !src_hit_ff && learn_ok;
      pop_ready = (state_ff == S_IDLE);

      result.egress_mask   = dst_hit_ff ? (MW'(1) << dst_port_ff) : work_ff.flood_mask;
      result.flooded       = !dst_hit_ff;
      result.learned       = !src_hit_ff && learn_ok;
      result.learn_dropped = !src_hit_ff && !learn_ok;
   end

   // learned address table, one read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IW-1:0]] <= '{mac: work_ff.src_mac, port: work_ff.in_port};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  work_ff      <= pop_data;
                  idx_ff       <= '0;
                  cmp_valid_ff <= 1'b0;
                  dst_hit_ff   <= 1'b0;
                  src_hit_ff   <= 1'b0;
                  state_ff     <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               cmp_valid_ff <= issue;
               if (issue) begin
                  idx_ff <= idx_ff + CW'(1);
               end
               if (dst_match) begin
                  dst_hit_ff  <= 1'b1;
                  dst_port_ff <= rd_data_ff.port;
               end
               if (src_match) begin
                  src_hit_ff <= 1'b1;
               end
               if (!issue && !cmp_valid_ff) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_ff <= result;
                  if (mem_we) begin
                     count_ff <= count_ff + CW'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- sv/mac_learning_forwarder_core.sv -----
// learning bridge address table: per frame header beat, the destination is looked up among
// the learned entries and either sent to its stored port or flooded to the active ports but
// the ingress one; an unknown source is then learned, or flagged when the table is full.
// entries are never updated or aged. the destination is found by a linear search over the N
// entries learned so far (at most TABLE_ENTRIES), which reads one entry per cycle from the
// table memory; the engine takes a new item only when idle. a two-beat queue sits between
// the request side and the search engine, and the response is held in an output register.
// csr_wr_data sets the number of active ports used for flooding (reset 8).
module mac_learning_forwarder_core #(
   parameter int TABLE_ENTRIES = mlf_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int MAX_PORTS     = mlf_pkg::MAX_PORTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [mlf_pkg::CSR_W-1:0] csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mlf_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mlf_pkg::rsp_type          rsp_payload
);

   logic              push_valid;
   logic              push_ready;
   mlf_pkg::work_type push_data;
   logic              pop_valid;
   logic              pop_ready;
   mlf_pkg::work_type pop_data;

   mlf_front #(
      .MAX_PORTS (MAX_PORTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   mlf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mlf_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // forwarded to a known port means exactly one port
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.flooded |-> $onehot(rsp_payload.egress_mask))
      else $error("known destination without a single egress port");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.learned && rsp_payload.learn_dropped))
      else $error("source both learned and dropped");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule
